// ===== rtl/wrocs_pkg.sv =====
// Shared types, widths and constants for the window rate-of-change spike core.
// Used by wrocs_ring, wrocs_div and window_rate_of_change_spike_core.
package wrocs_pkg;

    // Default depth of the sample window.
    localparam int WINDOW_DEF = 16;

    // Field widths.
    localparam int TEMP_W   = 16;
    localparam int RATE_W   = 27;
    localparam int AVG_W    = 16;
    localparam int PERIOD_W = 16;
    localparam int THR_W    = 26;
    localparam int RUN_W    = 8;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN = 2'd2;

    // Register reset values.
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd2000;
    localparam logic [THR_W-1:0]    THRESH_RST  = 26'd160;
    localparam logic [RUN_W-1:0]    MIN_RUN_RST = 8'd3;

    // Arithmetic constants: ms per minute, shortest span, run ceiling.
    localparam int MUL_W = 16;
    localparam logic [MUL_W-1:0] MS_PER_MIN = 16'd60000;
    localparam int               MIN_SPAN   = 60;
    localparam logic [RUN_W-1:0] RUN_MAX    = 8'd255;

    // Shared divider: numerator width and step counter width.
    localparam int DIV_NUM_W  = 32;
    localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);

endpackage

// ===== rtl/wrocs_ring.sv =====
// Sample window storage: one write port and one registered read port.
// Depends on wrocs_pkg for the sample width.
module wrocs_ring #(
    parameter int WINDOW = wrocs_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(WINDOW)-1:0]       i_waddr,
    input  logic [wrocs_pkg::TEMP_W-1:0]    i_wdata,
    input  logic [$clog2(WINDOW)-1:0]       i_raddr,
    output logic [wrocs_pkg::TEMP_W-1:0]    o_rdata
);

    logic [wrocs_pkg::TEMP_W-1:0] r_mem [WINDOW];
    logic [wrocs_pkg::TEMP_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wrocs_div.sv =====
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on wrocs_pkg for the numerator and step counter widths.
module wrocs_div #(
    parameter int DEN_W = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [wrocs_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]                    i_den,
    input  logic [wrocs_pkg::DIV_STEP_W-1:0]    i_steps,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [wrocs_pkg::DIV_NUM_W-1:0]     o_quo
);

    logic                               r_busy;
    logic                               r_done;
    logic [wrocs_pkg::DIV_STEP_W-1:0]   r_cnt;
    logic [DEN_W-1:0]                   r_den;
    logic [DEN_W-1:0]                   r_rem;
    logic [wrocs_pkg::DIV_NUM_W-1:0]    r_quo;
    logic [DEN_W+1:0]                   w_diff;
    logic                               w_fit;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign w_diff = {1'b0, r_rem, r_quo[wrocs_pkg::DIV_NUM_W-1]} - {2'b00, r_den};
    assign w_fit  = ~w_diff[DEN_W+1];

    // Control: load on start, count down the steps, flag the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == wrocs_pkg::DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: numerator bits shift out at the top as quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DEN_W-1:0]
                           : {r_rem[DEN_W-2:0], r_quo[wrocs_pkg::DIV_NUM_W-1]};
            r_quo <= {r_quo[wrocs_pkg::DIV_NUM_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/window_rate_of_change_spike_core.sv =====
// Top level of the window rate-of-change spike core: sequencer, registers,
// shared multiplier and output stage. Depends on wrocs_pkg, wrocs_ring, wrocs_div.
//
// Usage:
//   Temperature samples enter on the s_axis channel (tdata[15:0], signed,
//   1/16 degree C). Each sample yields one result on the m_axis channel:
//   rate over the window, a rate-valid flag, the window average and the
//   spike flag. Configuration registers (sample period, spike threshold,
//   minimum run) are written through i_cfg_we/i_cfg_index/i_cfg_data while
//   the core is idle.
//   The sequencer handles one sample at a time: after the input transfer
//   it reads the ring, runs two multiplies and then the shared divider,
//   which runs 32 steps for the rate and 16 + log2(WINDOW) steps for the
//   average, and only then presents the result. The next input transfer
//   waits until the sequencer has returned to idle.
//   s_axis_tready is high only while the sequencer is idle.
//   A finished result sits in an output register; the core accepts the next
//   sample while it waits, but will not finish that sample until the earlier
//   result has been transferred. A stalled receiver therefore stalls the core.
//   Reset (synchronous, active low) empties the window, clears the run count
//   and restores the register defaults; no clearing pass is needed.
module window_rate_of_change_spike_core #(
    parameter int WINDOW = wrocs_pkg::WINDOW_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Input stream.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [15:0] temperature
    input  logic [wrocs_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // Output stream.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [26:0] rate, [27] rate_valid, [43:28] average, [44] spike, [47:45] zero
    output logic [wrocs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // Configuration write port.
    input  logic                                    i_cfg_we,
    input  logic [wrocs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [wrocs_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int MAG_W  = PTR_W + 16;
    localparam int SUM_W  = MAG_W + 1;
    localparam int TW     = wrocs_pkg::TEMP_W;
    localparam int RW     = wrocs_pkg::RATE_W;
    localparam int AW     = wrocs_pkg::AVG_W;
    localparam int NW     = wrocs_pkg::DIV_NUM_W;
    localparam int MW     = wrocs_pkg::MUL_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD1   = 4'd1;
    localparam logic [3:0] S_RD2   = 4'd2;
    localparam logic [3:0] S_MSPAN = 4'd3;
    localparam logic [3:0] S_MNUM  = 4'd4;
    localparam logic [3:0] S_DGO   = 4'd5;
    localparam logic [3:0] S_DRATE = 4'd6;
    localparam logic [3:0] S_DAVG  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]                         r_state;
    logic [wrocs_pkg::PERIOD_W-1:0]     r_period;
    logic [wrocs_pkg::THR_W-1:0]        r_thresh;
    logic [wrocs_pkg::RUN_W-1:0]        r_min_run;
    logic [PTR_W-1:0]                   r_wp;
    logic [FILL_W-1:0]                  r_fill;
    logic signed [SUM_W-1:0]            r_sum;
    logic [wrocs_pkg::RUN_W-1:0]        r_run;
    logic [TW-1:0]                      r_temp;
    logic [MW-1:0]                      r_dmag;
    logic                               r_dneg;
    logic [NW-1:0]                      r_prod;
    logic [MAG_W-1:0]                   r_span;
    logic [RW-1:0]                      r_rate;
    logic [AW-1:0]                      r_avg;
    logic                               r_m_valid;
    logic [wrocs_pkg::OUT_TDATA_W-1:0]  r_m_data;

    logic                               w_full;
    logic                               w_rate_valid;
    logic [PTR_W-1:0]                   w_wp_inc;
    logic [PTR_W-1:0]                   w_raddr;
    logic [TW-1:0]                      w_rdata;
    logic                               w_we;
    logic [TW:0]                        w_delta;
    logic [MW-1:0]                      w_mul_a;
    logic [MW-1:0]                      w_mul_b;
    logic [NW-1:0]                      w_mul_p;
    logic [SUM_W-1:0]                   w_sum_abs;
    logic                               w_div_start;
    logic [NW-1:0]                      w_div_num;
    logic [MAG_W-1:0]                   w_div_den;
    logic [wrocs_pkg::DIV_STEP_W-1:0]   w_div_steps;
    logic                               w_div_busy;
    logic                               w_div_done;
    logic [NW-1:0]                      w_div_quo;
    logic [RW-1:0]                      w_qrate;
    logic [RW-1:0]                      w_rate_mag;
    logic [AW-1:0]                      w_qavg;
    logic [wrocs_pkg::RUN_W-1:0]        n_run;
    logic                               w_out_free;

    // Window status and ring addressing.
    assign w_full       = (r_fill == FILL_W'(WINDOW));
    assign w_rate_valid = (r_fill >= FILL_W'(2));
    assign w_wp_inc     = (r_wp == PTR_W'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
    assign w_raddr      = (r_state == S_RD1) ? r_wp : (w_full ? w_wp_inc : '0);
    assign w_we         = (r_state == S_RD2);

    wrocs_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (r_temp),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Newest minus oldest sample.
    assign w_delta = {r_temp[TW-1], r_temp} - {w_rdata[TW-1], w_rdata};

    // Shared multiplier: span in one state, scaled delta in the next.
    assign w_mul_a = (r_state == S_MSPAN) ? MW'(r_fill - FILL_W'(1)) : r_dmag;
    assign w_mul_b = (r_state == S_MSPAN) ? r_period : wrocs_pkg::MS_PER_MIN;
    assign w_mul_p = {{(NW - MW){1'b0}}, w_mul_a} * {{(NW - MW){1'b0}}, w_mul_b};

    // Divider operands: rate first, then the window average.
    assign w_sum_abs   = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign w_div_start = (r_state == S_DGO) || ((r_state == S_DRATE) && w_div_done);
    assign w_div_num   = (r_state == S_DGO) ? r_prod
                                            : {w_sum_abs[MAG_W-1:0], {(NW - MAG_W){1'b0}}};
    assign w_div_den   = (r_state == S_DGO) ? r_span : MAG_W'(r_fill);
    assign w_div_steps = (r_state == S_DGO) ? wrocs_pkg::DIV_STEP_W'(NW)
                                            : wrocs_pkg::DIV_STEP_W'(MAG_W);

    wrocs_div #(
        .DEN_W (MAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Rate magnitude and the over-threshold run counter.
    assign w_qrate    = w_div_quo[RW-1:0];
    assign w_rate_mag = w_rate_valid ? w_qrate : '0;
    assign w_qavg     = w_div_quo[AW-1:0];

    always_comb begin
        if (w_rate_mag >= {1'b0, r_thresh}) begin
            n_run = (r_run == wrocs_pkg::RUN_MAX) ? r_run : r_run + 1'b1;
        end else begin
            n_run = '0;
        end
    end

    assign w_out_free = !r_m_valid || m_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= wrocs_pkg::PERIOD_RST;
            r_thresh  <= wrocs_pkg::THRESH_RST;
            r_min_run <= wrocs_pkg::MIN_RUN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wrocs_pkg::CFG_PERIOD:  r_period  <= i_cfg_data[wrocs_pkg::PERIOD_W-1:0];
                wrocs_pkg::CFG_THRESH:  r_thresh  <= i_cfg_data[wrocs_pkg::THR_W-1:0];
                wrocs_pkg::CFG_MIN_RUN: r_min_run <= i_cfg_data[wrocs_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_run   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    // The evicted sample is on the read port now.
                    r_sum <= r_sum
                           - (w_full ? SUM_W'(signed'(w_rdata)) : '0)
                           + SUM_W'(signed'(r_temp));
                    r_wp  <= w_wp_inc;
                    if (!w_full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_MSPAN;
                end
                S_MSPAN: begin
                    r_state <= S_MNUM;
                end
                S_MNUM: begin
                    r_state <= S_DGO;
                end
                S_DGO: begin
                    r_state <= S_DRATE;
                end
                S_DRATE: begin
                    if (w_div_done) begin
                        r_run   <= n_run;
                        r_state <= S_DAVG;
                    end
                end
                S_DAVG: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_temp <= s_axis_tdata[TW-1:0];
        end
        if (r_state == S_MSPAN) begin
            r_dneg <= w_delta[TW];
            r_dmag <= w_delta[TW] ? MW'(-w_delta) : MW'(w_delta);
            r_prod <= w_mul_p;
        end
        if (r_state == S_MNUM) begin
            r_span <= (r_prod < NW'(wrocs_pkg::MIN_SPAN)) ? MAG_W'(wrocs_pkg::MIN_SPAN)
                                                          : r_prod[MAG_W-1:0];
            r_prod <= w_mul_p;
        end
        if ((r_state == S_DRATE) && w_div_done) begin
            r_rate <= r_dneg ? -w_rate_mag : w_rate_mag;
        end
        if ((r_state == S_DAVG) && w_div_done) begin
            r_avg <= r_sum[SUM_W-1] ? -w_qavg : w_qavg;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_m_data <= {3'b000, (r_run >= r_min_run), r_avg, w_rate_valid, r_rate};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // The write pointer follows the fill count until the window is full.
    a_wp_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < FILL_W'(WINDOW)) |-> (r_wp == PTR_W'(r_fill)))
        else $error("write pointer out of step with fill count");

    // The fill count never passes the window depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fill count beyond window depth");

    // No new sample is taken while the divider is still working.
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_div_busy)
        else $error("input ready while divider busy");

    // A result without a valid rate carries a zero rate.
    a_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[RW]) |-> (m_axis_tdata[RW-1:0] == '0))
        else $error("nonzero rate with rate_valid low");

    // An input transfer always starts a busy period.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after an input transfer");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for window_rate_of_change_spike_core: stream stimulus,
// register programming and a scoreboard with its own window predictor.
// Depends on wrocs_pkg and the core RTL.

// One result of the core, unpacked from the output stream.
typedef struct packed {
    logic [wrocs_pkg::RATE_W-1:0] rate;
    logic                         rate_valid;
    logic [wrocs_pkg::AVG_W-1:0]  average;
    logic                         spike;
} t_reading;

// Tracks the sample window and the register settings, predicts one reading per
// accepted sample and compares the readings that come out of the core.
class rate_scoreboard;
    logic signed [wrocs_pkg::TEMP_W-1:0] ring [wrocs_pkg::WINDOW_DEF];
    int unsigned                         wr_ptr;
    int unsigned                         fill;
    longint                              win_sum;
    int unsigned                         run_len;
    logic [wrocs_pkg::PERIOD_W-1:0]      period;
    logic [wrocs_pkg::THR_W-1:0]         thresh;
    logic [wrocs_pkg::RUN_W-1:0]         min_run;
    t_reading                            pending_readings [$];
    int                                  failures;

    function new();
        foreach (ring[k]) ring[k] = '0;
        wr_ptr   = 0;
        fill     = 0;
        win_sum  = 0;
        run_len  = 0;
        period   = wrocs_pkg::PERIOD_RST;
        thresh   = wrocs_pkg::THRESH_RST;
        min_run  = wrocs_pkg::MIN_RUN_RST;
        failures = 0;
    endfunction

    // A register write; unknown indexes leave every setting alone.
    function void apply_setting(logic [wrocs_pkg::CFG_IDX_W-1:0] idx,
                                logic [wrocs_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            wrocs_pkg::CFG_PERIOD:  period  = data[wrocs_pkg::PERIOD_W-1:0];
            wrocs_pkg::CFG_THRESH:  thresh  = data[wrocs_pkg::THR_W-1:0];
            wrocs_pkg::CFG_MIN_RUN: min_run = data[wrocs_pkg::RUN_W-1:0];
            default: ;
        endcase
    endfunction

    // Updates the window with an accepted sample and queues the reading it causes.
    function void note_sample(logic signed [wrocs_pkg::TEMP_W-1:0] temp);
        t_reading    want;
        longint      delta;
        longint      span;
        longint      rate_v;
        longint      mag;
        longint      avg;
        int unsigned oldest;
        int unsigned slot;

        slot = wr_ptr % wrocs_pkg::WINDOW_DEF;
        if (fill >= wrocs_pkg::WINDOW_DEF) win_sum -= longint'(ring[slot]);
        ring[slot] = temp;
        win_sum   += longint'(temp);
        wr_ptr     = (slot + 1) % wrocs_pkg::WINDOW_DEF;
        if (fill < wrocs_pkg::WINDOW_DEF) fill++;

        // Rate over the held span; a span shorter than the floor is raised to it.
        rate_v = 0;
        want.rate_valid = 1'b0;
        if (fill >= 2) begin
            oldest = (fill >= wrocs_pkg::WINDOW_DEF) ? wr_ptr : 0;
            delta  = longint'(temp) - longint'(ring[oldest]);
            span   = longint'(fill - 1) * longint'(period);
            if (span < longint'(wrocs_pkg::MIN_SPAN)) span = longint'(wrocs_pkg::MIN_SPAN);
            rate_v = (delta * 60000) / span;
            want.rate_valid = 1'b1;
        end
        avg = win_sum / longint'(fill);

        // Over-threshold run, saturating at its ceiling.
        mag = (rate_v < 0) ? -rate_v : rate_v;
        if (mag >= longint'(thresh)) begin
            if (run_len < 255) run_len++;
        end else begin
            run_len = 0;
        end

        want.rate    = rate_v[wrocs_pkg::RATE_W-1:0];
        want.average = avg[wrocs_pkg::AVG_W-1:0];
        want.spike   = (run_len >= min_run);
        pending_readings.push_back(want);
    endfunction

    function void report(string what);
        failures++;
        if (failures <= 10) $display("%s", what);
    endfunction

    // Compares one transferred result with the oldest pending reading.
    function void check_result(logic [wrocs_pkg::OUT_TDATA_W-1:0] data);
        t_reading got;
        t_reading want;

        got.rate       = data[26:0];
        got.rate_valid = data[27];
        got.average    = data[43:28];
        got.spike      = data[44];
        if (pending_readings.size() == 0) begin
            report($sformatf("unexpected result: rate %0d valid %0b average %0d spike %0b",
                             $signed(got.rate), got.rate_valid, $signed(got.average),
                             got.spike));
            return;
        end
        want = pending_readings.pop_front();
        if (got.rate !== want.rate || got.rate_valid !== want.rate_valid ||
            got.average !== want.average || got.spike !== want.spike) begin
            report($sformatf({"reading mismatch (expected/actual): rate %0d/%0d ",
                              "valid %0b/%0b average %0d/%0d spike %0b/%0b"},
                             $signed(want.rate), $signed(got.rate),
                             want.rate_valid, got.rate_valid,
                             $signed(want.average), $signed(got.average),
                             want.spike, got.spike));
        end
    endfunction
endclass

module tb;

    localparam int SETTLE_CYCLES  = 70;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int TIMEOUT_CYCLES = 1000000;

    // A register index beyond the register list.
    localparam logic [wrocs_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [wrocs_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [wrocs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              i_cfg_we      = 1'b0;
    logic [wrocs_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [wrocs_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;

    rate_scoreboard sb;
    bit             calm  = 1'b0;
    int             level = 0;
    int             slope = 0;

    window_rate_of_change_spike_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Random idle decision shared by both stream sides; off during calm stretches.
    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 16);
    endfunction

    // Presents one sample and holds it until the transfer happens.
    task automatic send_sample(input logic [wrocs_pkg::TEMP_W-1:0] temp);
        @(negedge i_clk);
        while (take_break()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= temp;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(temp);
    endtask

    // Writes one register; only called while the core is idle.
    task automatic program_reg(input logic [wrocs_pkg::CFG_IDX_W-1:0] idx,
                               input logic [wrocs_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.apply_setting(idx, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stops the input stream and waits until every pending reading has come out.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random register settings, with the extremes weighted in.
    task automatic choose_settings();
        logic [wrocs_pkg::CFG_DATA_W-1:0] junk;
        logic [wrocs_pkg::PERIOD_W-1:0]   per;
        logic [wrocs_pkg::THR_W-1:0]      thr;
        logic [wrocs_pkg::RUN_W-1:0]      run;
        int                               scale;

        junk = 26'($urandom);
        case ($urandom_range(0, 7))
            0:       per = 16'd0;
            1:       per = 16'd1;
            2:       per = 16'd59;
            3:       per = 16'd65535;
            4:       per = wrocs_pkg::PERIOD_RST;
            default: per = 16'($urandom_range(1, 65535));
        endcase
        scale = 8000000 / ((per < wrocs_pkg::MIN_SPAN) ? wrocs_pkg::MIN_SPAN : int'(per));
        case ($urandom_range(0, 7))
            0:       thr = '0;
            1:       thr = '1;
            2:       thr = 26'($urandom);
            default: thr = 26'($urandom_range(0, scale));
        endcase
        case ($urandom_range(0, 6))
            0:       run = 8'd0;
            1:       run = 8'd1;
            2:       run = 8'd255;
            3:       run = 8'($urandom_range(0, 255));
            default: run = 8'($urandom_range(1, 6));
        endcase
        program_reg(wrocs_pkg::CFG_PERIOD,
                    {junk[wrocs_pkg::CFG_DATA_W-1:wrocs_pkg::PERIOD_W], per});
        program_reg(wrocs_pkg::CFG_THRESH, thr);
        program_reg(wrocs_pkg::CFG_MIN_RUN,
                    {junk[wrocs_pkg::CFG_DATA_W-1:wrocs_pkg::RUN_W], run});
        if ($urandom_range(0, 2) == 0) program_reg(CFG_NONE, 26'($urandom));
        slope = $urandom_range(0, 600) - 300;
    endtask

    // Mostly smooth temperature traces (ramps, random walks, holds) with
    // occasional full-range jumps.
    task automatic random_burst(input int count);
        int style;
        int nv;

        for (int k = 0; k < count; k++) begin
            style = $urandom_range(0, 99);
            if (style < 15)
                nv = $signed(16'($urandom));
            else if (style < 25)
                nv = level;
            else if (style < 55)
                nv = level + slope;
            else
                nv = level + $urandom_range(0, 128) - 64;
            if (nv > 32767) nv = 32767;
            if (nv < -32768) nv = -32768;
            level = nv;
            send_sample(16'(nv));
        end
    endtask

    // Result side: random back-pressure, check on every transfer.
    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= !take_break();
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    // Run limit.
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence.
    initial begin
        int random_sent;
        int burst;

        sb = new();
        random_sent = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes while the window fills, at the reset settings.
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        settle();

        // Short span while the window fills up: the largest positive rate, an
        // unreachable threshold, the longest run, and an ignored write.
        program_reg(wrocs_pkg::CFG_PERIOD, 26'd1);
        program_reg(wrocs_pkg::CFG_THRESH, '1);
        program_reg(wrocs_pkg::CFG_MIN_RUN, 26'd255);
        program_reg(CFG_NONE, 26'($urandom));
        repeat (9) send_sample(16'h7FFF);
        settle();

        // Zero period, zero threshold, zero minimum run; largest negative rate.
        program_reg(wrocs_pkg::CFG_PERIOD, 26'd0);
        program_reg(wrocs_pkg::CFG_THRESH, 26'd0);
        program_reg(wrocs_pkg::CFG_MIN_RUN, 26'd0);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        settle();

        // Every sample over threshold long enough for the run count to saturate,
        // with no idling on either side.
        calm = 1'b1;
        program_reg(wrocs_pkg::CFG_PERIOD, 26'(wrocs_pkg::PERIOD_RST));
        program_reg(wrocs_pkg::CFG_THRESH, 26'd0);
        program_reg(wrocs_pkg::CFG_MIN_RUN, 26'd255);
        slope = 7;
        random_burst(280);
        random_sent += 280;
        settle();
        calm = 1'b0;

        // Random settings and traces, phase by phase.
        while (random_sent < RANDOM_ITEMS) begin
            choose_settings();
            burst = $urandom_range(60, 160);
            if (burst > RANDOM_ITEMS - random_sent) burst = RANDOM_ITEMS - random_sent;
            random_burst(burst);
            random_sent += burst;
            settle();
        end

        if (sb.failures == 0 && sb.pending_readings.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/wrocs_pkg.sv
rtl/wrocs_ring.sv
rtl/wrocs_div.sv
rtl/window_rate_of_change_spike_core.sv
tb/sv/tb.sv
